FILE: design/pli_pkg.sv
`timescale 1ns / 1ps
package pli_pkg;

	localparam int MAX_POINTS  = 16;
	localparam int NUM_GROUPS  = 2;
	localparam int QUEUE_DEPTH = 2;

	localparam int IDX_W  = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int ADDR_W = $clog2(NUM_GROUPS * MAX_POINTS);
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [2:0] {
		K_NOP,
		K_CLEAR,
		K_INSERT,
		K_QUERY,
		K_BAD_INSERT,
		K_BAD_QUERY
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic               grp;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} item_t;

endpackage

FILE: design/pli_ram.sv
`timescale 1ns / 1ps
module pli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/pli_front.sv
`timescale 1ns / 1ps
module pli_front import pli_pkg::*; (
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  op,
	input  logic        group,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] depth_z,
	input  logic        q_full,
	output logic        q_push,
	output item_t       q_item
);

	logic grp_ok;

	assign grp_ok     = 32'(group) < NUM_GROUPS;
	assign item_stall = q_full;
	assign q_push     = item_valid && !q_full;

	always_comb begin
		q_item.grp = group;
		q_item.x   = point_x;
		q_item.y   = point_y;
		q_item.z   = depth_z;
		unique case (op)
			OP_CLEAR:  q_item.kind = grp_ok ? K_CLEAR : K_NOP;
			OP_INSERT: q_item.kind = grp_ok ? K_INSERT : K_BAD_INSERT;
			OP_QUERY:  q_item.kind = grp_ok ? K_QUERY : K_BAD_QUERY;
			default:   q_item.kind = K_NOP;
		endcase
	end

endmodule

FILE: design/pli_queue.sv
`timescale 1ns / 1ps
module pli_queue import pli_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t pop_item,
	output logic  full,
	output logic  nempty
);

	item_t             ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign nempty   = cnt_q != '0;
	assign pop_item = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (32'(wr_q) == QUEUE_DEPTH - 1) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (32'(rd_q) == QUEUE_DEPTH - 1) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/pli_back.sv
`timescale 1ns / 1ps
module pli_back import pli_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_nempty,
	input  item_t q_item,
	output logic  q_pop,
	output logic  result_valid,
	input  logic  result_stall,
	output logic signed [31:0] value,
	output logic  clamped_low,
	output logic  clamped_high,
	output logic [1:0] status
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_INS_RD  = 4'd1;
	localparam logic [3:0] S_INS_CHK = 4'd2;
	localparam logic [3:0] S_INS_WR  = 4'd3;
	localparam logic [3:0] S_Q0_RD   = 4'd4;
	localparam logic [3:0] S_Q0_CHK  = 4'd5;
	localparam logic [3:0] S_QL_RD   = 4'd6;
	localparam logic [3:0] S_QL_CHK  = 4'd7;
	localparam logic [3:0] S_QS_RD   = 4'd8;
	localparam logic [3:0] S_QS_CHK  = 4'd9;
	localparam logic [3:0] S_MUL1    = 4'd10;
	localparam logic [3:0] S_MUL2    = 4'd11;
	localparam logic [3:0] S_MUL3    = 4'd12;
	localparam logic [3:0] S_DIV     = 4'd13;
	localparam logic [3:0] S_OUT     = 4'd14;

	logic [3:0]        state_q;
	logic [CNT_W-1:0]  cnt_q [NUM_GROUPS];
	logic              grp_q;
	logic [ADDR_W-1:0] base_q;
	logic [CNT_W-1:0]  n_q;
	logic [IDX_W-1:0]  k_q;
	logic [IDX_W-1:0]  rd_q;
	logic signed [31:0] px_q, py_q, z_q;
	logic signed [31:0] x0_q, y0_q;
	logic [31:0]       a_q, dx_q;
	logic [32:0]       mag_q;
	logic              neg_q;
	logic [47:0]       plo_q;
	logic [48:0]       phi_q;
	logic [31:0]       rem_q;
	logic [32:0]       qsh_q;
	logic [5:0]        dcnt_q;
	logic signed [31:0] res_val_q;
	logic              res_lo_q, res_hi_q;
	logic [1:0]        res_st_q;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [31:0]       wx, wy;
	logic signed [31:0] rx, ry;
	logic [CNT_W-1:0]  n_sel;
	logic signed [32:0] dy;
	logic [63:0]       prod;
	logic [32:0]       trial;
	logic              tbit;
	logic [31:0]       rem_nx;
	logic [32:0]       qsh_nx;

	pli_ram #(.WIDTH(32), .DEPTH(NUM_GROUPS * MAX_POINTS)) u_ram_x (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wx),
		.raddr(base_q + ADDR_W'(rd_q)), .rdata(rx)
	);

	pli_ram #(.WIDTH(32), .DEPTH(NUM_GROUPS * MAX_POINTS)) u_ram_y (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wy),
		.raddr(base_q + ADDR_W'(rd_q)), .rdata(ry)
	);

	assign n_sel = cnt_q[q_item.grp];
	assign q_pop = state_q == S_IDLE && q_nempty;
	assign dy    = 33'(ry) - 33'(y0_q);
	assign prod  = 64'({phi_q, 16'b0}) + 64'(plo_q);
	assign trial = {rem_q, qsh_q[32]} - {1'b0, dx_q};
	assign tbit  = !trial[32];
	assign rem_nx = tbit ? trial[31:0] : {rem_q[30:0], qsh_q[32]};
	assign qsh_nx = {qsh_q[31:0], tbit};

	always_comb begin
		we    = 1'b0;
		waddr = base_q + ADDR_W'(k_q);
		wx    = px_q;
		wy    = py_q;
		if (state_q == S_INS_CHK && rx > px_q) begin
			we = 1'b1;
			wx = rx;
			wy = ry;
		end else if (state_q == S_INS_WR) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				grp_q  <= q_item.grp;
				base_q <= ADDR_W'(32'(q_item.grp) * MAX_POINTS);
				px_q   <= q_item.x;
				py_q   <= q_item.y;
				z_q    <= q_item.z;
				n_q    <= n_sel;
				k_q    <= IDX_W'(n_sel);
				rd_q   <= (q_item.kind == K_INSERT) ? IDX_W'(n_sel - 1'b1) : '0;
				res_val_q <= '0;
				res_lo_q  <= 1'b0;
				res_hi_q  <= 1'b0;
				unique case (q_item.kind)
					K_INSERT:     res_st_q <= (32'(n_sel) == MAX_POINTS) ? ST_FULL : ST_OK;
					K_QUERY:      res_st_q <= (n_sel == '0) ? ST_EMPTY : ST_OK;
					K_BAD_INSERT: res_st_q <= ST_FULL;
					K_BAD_QUERY:  res_st_q <= ST_EMPTY;
					default:      res_st_q <= ST_OK;
				endcase
			end
			S_INS_CHK: begin
				if (rx > px_q) begin
					k_q  <= k_q - 1'b1;
					rd_q <= k_q - IDX_W'(2);
				end
			end
			S_Q0_CHK: begin
				if (z_q <= rx) begin
					res_val_q <= ry;
					res_lo_q  <= 1'b1;
				end
				x0_q <= rx;
				y0_q <= ry;
				rd_q <= IDX_W'(n_q - 1'b1);
			end
			S_QL_CHK: begin
				if (z_q >= rx) begin
					res_val_q <= ry;
					res_hi_q  <= 1'b1;
				end
				rd_q <= IDX_W'(1);
			end
			S_QS_CHK: begin
				if (rx > z_q) begin
					a_q   <= 32'(z_q - x0_q);
					dx_q  <= 32'(rx - x0_q);
					neg_q <= dy[32];
					mag_q <= dy[32] ? 33'(-dy) : 33'(dy);
				end else begin
					x0_q <= rx;
					y0_q <= ry;
					rd_q <= rd_q + 1'b1;
				end
			end
			S_MUL1: plo_q <= a_q * mag_q[15:0];
			S_MUL2: phi_q <= a_q * mag_q[32:16];
			S_MUL3: begin
				rem_q  <= {1'b0, prod[63:33]};
				qsh_q  <= prod[32:0];
				dcnt_q <= 6'd33;
			end
			S_DIV: begin
				rem_q  <= rem_nx;
				qsh_q  <= qsh_nx;
				dcnt_q <= dcnt_q - 1'b1;
				if (dcnt_q == 6'd1) begin
					res_val_q <= neg_q ? y0_q - $signed(qsh_nx[31:0])
						: y0_q + $signed(qsh_nx[31:0]);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			result_valid <= 1'b0;
			for (int g = 0; g < NUM_GROUPS; g++) begin
				cnt_q[g] <= '0;
			end
		end else begin
			if (result_valid && !result_stall) begin
				result_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_nempty) begin
						unique case (q_item.kind)
							K_CLEAR: begin
								cnt_q[q_item.grp] <= '0;
								state_q <= S_OUT;
							end
							K_INSERT: begin
								if (32'(n_sel) == MAX_POINTS) begin
									state_q <= S_OUT;
								end else if (n_sel == '0) begin
									state_q <= S_INS_WR;
								end else begin
									state_q <= S_INS_RD;
								end
							end
							K_QUERY: state_q <= (n_sel == '0) ? S_OUT : S_Q0_RD;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_INS_RD: state_q <= S_INS_CHK;
				S_INS_CHK: begin
					if (rx > px_q && k_q != IDX_W'(1)) begin
						state_q <= S_INS_RD;
					end else begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					cnt_q[grp_q] <= n_q + 1'b1;
					state_q <= S_OUT;
				end
				S_Q0_RD:  state_q <= S_Q0_CHK;
				S_Q0_CHK: state_q <= (z_q <= rx) ? S_OUT : S_QL_RD;
				S_QL_RD:  state_q <= S_QL_CHK;
				S_QL_CHK: state_q <= (z_q >= rx) ? S_OUT : S_QS_RD;
				S_QS_RD:  state_q <= S_QS_CHK;
				S_QS_CHK: state_q <= (rx > z_q) ? S_MUL1 : S_QS_RD;
				S_MUL1:   state_q <= S_MUL2;
				S_MUL2:   state_q <= S_MUL3;
				S_MUL3:   state_q <= S_DIV;
				S_DIV:    state_q <= (dcnt_q == 6'd1) ? S_OUT : S_DIV;
				S_OUT: begin
					if (!result_valid || !result_stall) begin
						result_valid <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!result_valid || !result_stall)) begin
			value        <= res_val_q;
			clamped_low  <= res_lo_q;
			clamped_high <= res_hi_q;
			status       <= res_st_q;
		end
	end

endmodule

FILE: design/piecewise_linear_interpolator.sv
`timescale 1ns / 1ps
// Piecewise linear interpolator over per-group breakpoint tables kept sorted by x.
// Each transaction (clear, insert, query or unused op) yields one result transaction.
// A clear, an empty-group query or an error case goes straight to the output state; an
// insert moves each breakpoint of larger x up one slot and then writes the new one (at
// once into an empty group); a query that clamps stops after checking the first (low)
// or last (high) breakpoint; an interpolating query scans segments, then runs the
// 3-step multiply and the restoring divider. The table RAM's registered read gives each
// scan step a read state and a check state. A 2-entry queue lets new transactions be
// taken while the previous one is being processed.
module piecewise_linear_interpolator import pli_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  op,
	input  logic        group,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] depth_z,
	output logic        result_valid,
	input  logic        result_stall,
	output logic signed [31:0] value,
	output logic        clamped_low,
	output logic        clamped_high,
	output logic [1:0]  status
);

	logic  q_full, q_push, q_pop, q_nempty;
	item_t push_item, pop_item;

	pli_front u_front (
		.item_valid(item_valid), .item_stall(item_stall), .op(op), .group(group),
		.point_x(point_x), .point_y(point_y), .depth_z(depth_z),
		.q_full(q_full), .q_push(q_push), .q_item(push_item)
	);

	pli_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_item(push_item),
		.pop(q_pop), .pop_item(pop_item), .full(q_full), .nempty(q_nempty)
	);

	pli_back u_back (
		.clk(clk), .arst_n(arst_n), .q_nempty(q_nempty), .q_item(pop_item),
		.q_pop(q_pop), .result_valid(result_valid), .result_stall(result_stall),
		.value(value), .clamped_low(clamped_low), .clamped_high(clamped_high),
		.status(status)
	);

endmodule

FILE: test/piecewise_linear_interpolator_tb.sv
`timescale 1ns / 1ps
module piecewise_linear_interpolator_tb;
	import pli_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic signed [31:0] value;
		logic               lo;
		logic               hi;
		logic [1:0]         st;
	} answer_t;

	class interp_scoreboard;
		logic signed [31:0] tx [NUM_GROUPS][MAX_POINTS];
		logic signed [31:0] ty [NUM_GROUPS][MAX_POINTS];
		int                 cnt [NUM_GROUPS];
		answer_t            pending [$];
		int                 errors;

		function void note_item(logic [1:0] o, logic g, logic signed [31:0] px,
				logic signed [31:0] py, logic signed [31:0] z);
			answer_t a;
			int pos, n, i;
			longint x0, x1, y0, dy, d, mag;
			a.value = 0;
			a.lo = 0;
			a.hi = 0;
			a.st = ST_OK;
			if (o == OP_CLEAR) begin
				cnt[g] = 0;
			end else if (o == OP_INSERT) begin
				n = cnt[g];
				if (n >= MAX_POINTS) begin
					a.st = ST_FULL;
				end else begin
					pos = 0;
					while (pos < n && tx[g][pos] <= px) pos++;
					for (i = n; i > pos; i--) begin
						tx[g][i] = tx[g][i-1];
						ty[g][i] = ty[g][i-1];
					end
					tx[g][pos] = px;
					ty[g][pos] = py;
					cnt[g] = n + 1;
				end
			end else if (o == OP_QUERY) begin
				n = cnt[g];
				if (n == 0) begin
					a.st = ST_EMPTY;
				end else if (z <= tx[g][0]) begin
					a.value = ty[g][0];
					a.lo = 1;
				end else if (z >= tx[g][n-1]) begin
					a.value = ty[g][n-1];
					a.hi = 1;
				end else begin
					for (i = 0; i + 1 < n; i++) begin
						x0 = tx[g][i];
						x1 = tx[g][i+1];
						if (z >= x0 && z < x1) begin
							y0 = ty[g][i];
							dy = longint'(ty[g][i+1]) - y0;
							mag = dy < 0 ? -dy : dy;
							d = longint'($unsigned((longint'(z) - x0) * mag)
								/ $unsigned(x1 - x0));
							a.value = 32'(dy < 0 ? y0 - d : y0 + d);
							break;
						end
					end
				end
			end
			pending.push_back(a);
		endfunction

		function void check_result(logic signed [31:0] v, logic l, logic h, logic [1:0] s);
			answer_t a;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result value=%0d", $time, v);
				errors++;
				return;
			end
			a = pending.pop_front();
			if (v !== a.value) begin
				$display("%0t: value exp %0d got %0d", $time, a.value, v);
				errors++;
			end
			if (l !== a.lo) begin
				$display("%0t: clamped_low exp %0b got %0b", $time, a.lo, l);
				errors++;
			end
			if (h !== a.hi) begin
				$display("%0t: clamped_high exp %0b got %0b", $time, a.hi, h);
				errors++;
			end
			if (s !== a.st) begin
				$display("%0t: status exp %0d got %0d", $time, a.st, s);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic item_valid, item_stall;
	logic [1:0] op;
	logic group;
	logic signed [31:0] point_x, point_y, depth_z;
	logic result_valid, result_stall;
	logic signed [31:0] value;
	logic clamped_low, clamped_high;
	logic [1:0] status;

	interp_scoreboard sb;
	longint cycles;
	bit hold_rx;
	int burst_left;

	piecewise_linear_interpolator DUT (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("piecewise_linear_interpolator_tb: FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && result_valid && !result_stall)
			sb.check_result(value, clamped_low, clamped_high, status);

	// receiver stall pattern, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_rx)
			result_stall <= 1;
		else
			case ($urandom_range(0, 3))
				0: result_stall <= 1;
				default: result_stall <= ($urandom_range(0, 9) == 0);
			endcase
	end

	task automatic send(logic [1:0] o, logic g, logic signed [31:0] px,
			logic signed [31:0] py, logic signed [31:0] z);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				item_valid <= 0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		item_valid <= 1;
		op <= o;
		group <= g;
		point_x <= px;
		point_y <= py;
		depth_z <= z;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sb.note_item(o, g, px, py, z);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic drain();
		item_valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	function automatic logic signed [31:0] rnd32();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(0, 4000)) - 2000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int i, k, o;
		logic g;
		logic signed [31:0] z;
		sb = new();
		cycles = 0;
		hold_rx = 0;
		burst_left = 0;
		arst_n = 0;
		item_valid = 0;
		result_stall = 0;
		op = OP_CLEAR;
		group = 0;
		point_x = 0;
		point_y = 0;
		depth_z = 0;
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed
		send(OP_QUERY, 0, 0, 0, 5);
		send(OP_QUERY, 1, 0, 0, 32'sh80000000);
		send(OP_INSERT, 0, 100, 1000, 0);
		send(OP_QUERY, 0, 0, 0, 100);
		send(OP_QUERY, 0, 0, 0, 200);
		send(OP_INSERT, 0, 32'sh80000000, 32'sh7fffffff, 0);
		send(OP_INSERT, 0, 32'sh7fffffff, 32'sh80000000, 0);
		send(OP_INSERT, 0, 100, -500, 0);
		send(OP_QUERY, 0, 0, 0, 0);
		send(OP_QUERY, 0, 0, 0, 100);
		send(OP_QUERY, 0, 0, 0, 1000000);
		send(OP_QUERY, 0, 0, 0, 32'sh7fffffff);
		send(OP_QUERY, 0, 0, 0, 32'sh80000000);
		send(OP_UNUSED, 1, 32'shffffffff, 32'shffffffff, 32'shffffffff);
		for (i = 0; i < MAX_POINTS + 1; i++)
			send(OP_INSERT, 1, i * 256, i * 1024 - 3, 0);
		send(OP_QUERY, 1, 0, 0, 700);
		send(OP_CLEAR, 0, 0, 0, 0);
		send(OP_QUERY, 0, 0, 0, 7);
		drain();

		// random: mostly build tables then query
		for (k = 0; k < 40; k++) begin
			g = $urandom_range(0, 1);
			if ($urandom_range(0, 3) != 0) send(OP_CLEAR, g, rnd32(), rnd32(), rnd32());
			for (i = $urandom_range(1, 18); i > 0; i--)
				send(OP_INSERT, g, rnd32(), rnd32(), rnd32());
			for (i = $urandom_range(2, 8); i > 0; i--) begin
				o = $urandom_range(0, 19);
				z = rnd32();
				if (o == 0) send(OP_UNUSED, $urandom_range(0, 1), rnd32(), rnd32(), z);
				else if (o == 1) send(OP_CLEAR, $urandom_range(0, 1), rnd32(), rnd32(), z);
				else send(OP_QUERY, (o == 2) ? ~g : g, rnd32(), rnd32(), z);
			end
			if (k == 10) begin
				hold_rx = 1;
				fork
					begin
						repeat (300) @(negedge clk);
						hold_rx = 0;
					end
					for (i = 0; i < 8; i++) send(OP_QUERY, g, 0, 0, rnd32());
				join
			end
			if (k == 25) drain();
		end
		drain();
		repeat (200) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("piecewise_linear_interpolator_tb: PASS");
		else
			$display("piecewise_linear_interpolator_tb: FAIL");
		$finish;
	end
endmodule

FILE: piecewise_linear_interpolator.f
design/pli_pkg.sv
design/pli_ram.sv
design/pli_front.sv
design/pli_queue.sv
design/pli_back.sv
design/piecewise_linear_interpolator.sv
test/piecewise_linear_interpolator_tb.sv
